// ===== design/cwa_pkg.sv =====
package cwa_pkg;

  // Input request kinds carried on the slave tuser
  typedef enum logic [1:0] {
    MODE_TICK      = 2'd0,
    MODE_LOAD_TIME = 2'd1,
    MODE_LOAD_DATE = 2'd2
  } mode_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TICKS_PER_SEC = 2'd0,
    REG_ALARM_HOURS   = 2'd1,
    REG_ALARM_MINUTES = 2'd2,
    REG_ALARM_SECONDS = 2'd3
  } reg_idx_e;

  localparam logic [7:0]  TicksPerSecReset = 8'd6;
  localparam logic [4:0]  HourReset        = 5'd18;
  localparam logic [4:0]  DayReset         = 5'd1;
  localparam logic [3:0]  MonthReset       = 4'd1;
  localparam logic [13:0] YearReset        = 14'd1991;

  localparam logic [4:0]  MaxHour   = 5'd23;
  localparam logic [5:0]  MaxMinSec = 6'd59;
  localparam logic [3:0]  MaxMonth  = 4'd12;
  localparam logic [13:0] MaxYear   = 14'd9999;

  // Divisibility by 25: multiply by the inverse of 25 modulo 2^14 and
  // compare against floor((2^14 - 1) / 25)
  localparam logic [13:0] Inv25    = 14'd7209;
  localparam logic [13:0] Div25Max = 14'd655;

  // Calendar and time state
  typedef struct packed {
    logic [7:0]  tick;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } clk_state_t;

  // Per-request status flags
  typedef struct packed {
    logic second_pulse;
    logic new_day;
    logic load_rejected;
  } step_flags_t;

  // Gregorian leap year
  function automatic logic is_leap(logic [13:0] y);
    logic [13:0] prod;
    logic        div25;
    prod  = y * Inv25;
    div25 = (prod <= Div25Max);
    if (y[1:0] != 2'd0) begin
      return 1'b0;
    end
    if (!div25) begin
      return 1'b1;
    end
    return (y[3:0] == 4'd0);
  endfunction

  // Days in month m (1..12) of year y
  function automatic logic [4:0] days_in(logic [3:0] m, logic [13:0] y);
    logic [4:0] len;
    unique case (m)
      4'd2:    len = is_leap(y) ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== design/calendar_clock_with_alarm.sv =====
// Real-time clock and calendar with alarm compare. Every request on the slave
// stream (tuser = mode: tick, load time, load date) produces exactly one
// result on the master stream in the cycle after it is accepted. The block takes
// one request per clock cycle: the time/date update is one pass of
// increment-and-compare logic between the state registers and the result
// register, and a new request is accepted whenever the result register is
// empty or being drained in the same cycle. After reset the time is 18:00:00
// on 1 January 1991 and one second passes every 6 ticks. Configuration writes
// (ticks per second, alarm h/m/s) take effect on the next request.
module calendar_clock_with_alarm import cwa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata, low bit up: set_hours[6:0], set_minutes[13:7], set_seconds[20:14],
  //   set_day[27:21], set_month[34:28], set_year[48:35], zero pad[55:49]
  input  logic [55:0] s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata, low bit up: hours[4:0], minutes[10:5], seconds[16:11],
  //   day_of_month[21:17], month_number[25:22], year_number[39:26],
  //   second_pulse[40], new_day[41], alarm_match[42], load_rejected[43],
  //   zero pad[47:44]
  output logic [47:0] m_axis_tdata
);

  logic [7:0]  tps_q;
  logic [4:0]  alarm_h_q;
  logic [5:0]  alarm_m_q;
  logic [5:0]  alarm_s_q;
  clk_state_t  state_q, state_d;
  step_flags_t flags;
  logic        accept;
  logic        alarm_hit;
  logic        out_valid_q;
  logic [43:0] out_data_q, out_data_d;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q     <= TicksPerSecReset;
      alarm_h_q <= '0;
      alarm_m_q <= '0;
      alarm_s_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_TICKS_PER_SEC: tps_q     <= cfg_wdata_i;
        REG_ALARM_HOURS:   alarm_h_q <= cfg_wdata_i[4:0];
        REG_ALARM_MINUTES: alarm_m_q <= cfg_wdata_i[5:0];
        REG_ALARM_SECONDS: alarm_s_q <= cfg_wdata_i[5:0];
        default: begin
        end
      endcase
    end
  end

  // Accept when the result slot is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cwa_step u_step (
    .state_i        (state_q),
    .ticks_per_sec_i(tps_q),
    .mode_i         (s_axis_tuser),
    .set_hours_i    (s_axis_tdata[6:0]),
    .set_minutes_i  (s_axis_tdata[13:7]),
    .set_seconds_i  (s_axis_tdata[20:14]),
    .set_day_i      (s_axis_tdata[27:21]),
    .set_month_i    (s_axis_tdata[34:28]),
    .set_year_i     (s_axis_tdata[48:35]),
    .state_o        (state_d),
    .flags_o        (flags)
  );

  // Clock and calendar state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{tick: '0, hour: HourReset, minute: '0, second: '0,
                   day: DayReset, month: MonthReset, year: YearReset};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Alarm compare against the updated time
  assign alarm_hit = (state_d.hour == alarm_h_q) && (state_d.minute == alarm_m_q) &&
                     (state_d.second == alarm_s_q);

  assign out_data_d = {flags.load_rejected, alarm_hit, flags.new_day, flags.second_pulse,
                       state_d.year, state_d.month, state_d.day,
                       state_d.second, state_d.minute, state_d.hour};

  // Result register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_data_q};

endmodule

// ===== design/cwa_step.sv =====
module cwa_step import cwa_pkg::*; (
  input  clk_state_t  state_i,
  input  logic [7:0]  ticks_per_sec_i,
  input  logic [1:0]  mode_i,
  input  logic [6:0]  set_hours_i,
  input  logic [6:0]  set_minutes_i,
  input  logic [6:0]  set_seconds_i,
  input  logic [6:0]  set_day_i,
  input  logic [6:0]  set_month_i,
  input  logic [13:0] set_year_i,
  output clk_state_t  state_o,
  output step_flags_t flags_o
);

  logic [7:0] limit;
  logic [8:0] cnt;
  logic       sec_wrap, min_wrap, hour_wrap;
  logic [3:0] cur_month;
  logic       day_wrap;
  logic       time_ok, date_ok;
  logic       month_ok;

  // Prescaler: a zero limit behaves as one
  assign limit = (ticks_per_sec_i == 8'd0) ? 8'd1 : ticks_per_sec_i;
  assign cnt   = {1'b0, state_i.tick} + 9'd1;

  // Carry chain through seconds, minutes, hours
  assign sec_wrap  = (state_i.second >= MaxMinSec);
  assign min_wrap  = (state_i.minute >= MaxMinSec);
  assign hour_wrap = (state_i.hour >= MaxHour);

  // Day carry uses a sane month in case the register holds garbage
  assign cur_month = (state_i.month >= 4'd1 && state_i.month <= MaxMonth) ?
                     state_i.month : 4'd1;
  assign day_wrap  = ({1'b0, state_i.day} + 6'd1) > {1'b0, days_in(cur_month, state_i.year)};

  // Load range checks
  assign time_ok  = (set_hours_i <= 7'd23) && (set_minutes_i <= 7'd59) &&
                    (set_seconds_i <= 7'd59);
  assign month_ok = (set_month_i >= 7'd1) && (set_month_i <= 7'd12);
  assign date_ok  = month_ok && (set_year_i <= MaxYear) && (set_day_i >= 7'd1) &&
                    (set_day_i <= {2'b00, days_in(set_month_i[3:0], set_year_i)});

  always_comb begin
    state_o = state_i;
    flags_o = '0;
    unique case (mode_i)
      MODE_TICK: begin
        if (cnt >= {1'b0, limit}) begin
          state_o.tick         = '0;
          flags_o.second_pulse = 1'b1;
          // advance one second
          if (!sec_wrap) begin
            state_o.second = state_i.second + 6'd1;
          end else begin
            state_o.second = '0;
            if (!min_wrap) begin
              state_o.minute = state_i.minute + 6'd1;
            end else begin
              state_o.minute = '0;
              if (!hour_wrap) begin
                state_o.hour = state_i.hour + 5'd1;
              end else begin
                // midnight: advance the date
                state_o.hour    = '0;
                flags_o.new_day = 1'b1;
                if (!day_wrap) begin
                  state_o.day = state_i.day + 5'd1;
                end else begin
                  state_o.day = 5'd1;
                  if (cur_month < MaxMonth) begin
                    state_o.month = cur_month + 4'd1;
                  end else begin
                    state_o.month = 4'd1;
                    state_o.year  = (state_i.year >= MaxYear) ? 14'd0 :
                                    state_i.year + 14'd1;
                  end
                end
              end
            end
          end
        end else begin
          state_o.tick = cnt[7:0];
        end
      end
      MODE_LOAD_TIME: begin
        if (time_ok) begin
          state_o.hour   = set_hours_i[4:0];
          state_o.minute = set_minutes_i[5:0];
          state_o.second = set_seconds_i[5:0];
        end else begin
          flags_o.load_rejected = 1'b1;
        end
      end
      MODE_LOAD_DATE: begin
        if (date_ok) begin
          state_o.day   = set_day_i[4:0];
          state_o.month = set_month_i[3:0];
          state_o.year  = set_year_i;
        end else begin
          flags_o.load_rejected = 1'b1;
        end
      end
      default: begin
        // unused mode: hold state
      end
    endcase
  end

endmodule

// ===== design/cwa_chk.sv =====
module cwa_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A ready consumer never stalls the request side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("request side stalled with ready consumer");

  // A new day only comes with a second pulse at midnight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[41] |->
      m_axis_tdata[40] && m_axis_tdata[16:0] == 17'd0)
    else $error("new day without midnight rollover");

  // A rejected load never advances the time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[43] |-> !m_axis_tdata[40] && !m_axis_tdata[41])
    else $error("rejected load with time pulse");

  // Every accepted request yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("missing result after accepted request");

endmodule

bind calendar_clock_with_alarm cwa_chk u_cwa_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ===== tb/sv/calendar_clock_with_alarm_tb.sv =====
module calendar_clock_with_alarm_tb;
  import cwa_pkg::*;

  // Mode code 3 has no meaning in the block; it must leave the state alone
  localparam mode_e MODE_UNUSED = mode_e'(2'd3);
  localparam int StallLimit = 1000;
  localparam int PhaseRequests = 250;
  localparam int IdlePercent = 28;

  // One request as the block sees it
  typedef struct packed {
    mode_e       mode;
    logic [13:0] set_year;
    logic [6:0]  set_month;
    logic [6:0]  set_day;
    logic [6:0]  set_second;
    logic [6:0]  set_minute;
    logic [6:0]  set_hour;
  } request_t;

  // One clock reading, laid out exactly as the low 44 bits of m_axis_tdata
  typedef struct packed {
    logic        load_rejected;
    logic        alarm_match;
    logic        new_day;
    logic        second_pulse;
    logic [13:0] year_number;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
  } reading_t;

  typedef struct packed {
    request_t rq;
    logic     typed;
    reading_t want;
  } table_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  reg_idx_e    cfg_idx_i = REG_TICKS_PER_SEC;
  logic [7:0]  cfg_wdata_i = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata, low bit up: set_hours, set_minutes, set_seconds, set_day, set_month,
  //   set_year, zero pad
  logic [55:0] s_axis_tdata = 56'd0;
  // tuser: mode
  logic [1:0]  s_axis_tuser = 2'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata, low bit up: hours, minutes, seconds, day_of_month, month_number,
  //   year_number, second_pulse, new_day, alarm_match, load_rejected, zero pad
  logic [47:0] m_axis_tdata;

  // Shadow calendar state and registers
  logic [7:0]  tick_cnt = 8'd0;
  logic [4:0]  hh = 5'd18;
  logic [5:0]  mm = 6'd0;
  logic [5:0]  ss = 6'd0;
  logic [4:0]  dd = 5'd1;
  logic [3:0]  mo = 4'd1;
  logic [13:0] yy = 14'd1991;
  logic [7:0]  tps_q = 8'd6;
  logic [4:0]  alm_h = 5'd0;
  logic [5:0]  alm_m = 6'd0;
  logic [5:0]  alm_s = 6'd0;

  reading_t   pending_readings[$];
  table_row_t directed_rows[$];
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  bit         steady = 1'b0;

  calendar_clock_with_alarm dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit leap_year(int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int month_days(int m, int y);
    case (m)
      2:            return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  function automatic request_t make_request(mode_e mode, int h, int m, int s,
                                            int d, int mon, int y);
    request_t rq;
    rq.mode       = mode;
    rq.set_hour   = 7'(h);
    rq.set_minute = 7'(m);
    rq.set_second = 7'(s);
    rq.set_day    = 7'(d);
    rq.set_month  = 7'(mon);
    rq.set_year   = 14'(y);
    return rq;
  endfunction

  function automatic reading_t clock_reading(int h, int m, int s, int d, int mon, int y,
                                             bit pulse, bit nday, bit hit, bit rej);
    reading_t r;
    r.hours         = 5'(h);
    r.minutes       = 6'(m);
    r.seconds       = 6'(s);
    r.day_of_month  = 5'(d);
    r.month_number  = 4'(mon);
    r.year_number   = 14'(y);
    r.second_pulse  = pulse;
    r.new_day       = nday;
    r.alarm_match   = hit;
    r.load_rejected = rej;
    return r;
  endfunction

  function automatic string show_reading(reading_t r);
    return $sformatf("%0d:%0d:%0d %0d/%0d/%0d pulse=%0d new_day=%0d alarm=%0d rejected=%0d",
                     r.hours, r.minutes, r.seconds, r.day_of_month, r.month_number,
                     r.year_number, r.second_pulse, r.new_day, r.alarm_match,
                     r.load_rejected);
  endfunction

  // Apply one request to the shadow calendar and return the reading it yields
  function automatic reading_t advance_calendar(request_t rq);
    reading_t r;
    int limit;
    int cnt;
    int m;
    bit pulse;
    bit nday;
    bit rej;
    pulse = 1'b0;
    nday  = 1'b0;
    rej   = 1'b0;
    case (rq.mode)
      MODE_TICK: begin
        limit = (tps_q == 8'd0) ? 1 : int'(tps_q);
        cnt   = tick_cnt + 1;
        if (cnt >= limit) begin
          tick_cnt = 8'd0;
          pulse    = 1'b1;
          // ripple seconds into minutes into hours
          if (ss >= 6'd59) begin
            ss = 6'd0;
            if (mm >= 6'd59) begin
              mm = 6'd0;
              if (hh >= 5'd23) begin
                hh   = 5'd0;
                nday = 1'b1;
              end else begin
                hh = hh + 5'd1;
              end
            end else begin
              mm = mm + 6'd1;
            end
          end else begin
            ss = ss + 6'd1;
          end
          // midnight moves the date on
          if (nday) begin
            m = (mo >= 4'd1 && mo <= 4'd12) ? int'(mo) : 1;
            if (int'(dd) >= month_days(m, yy)) begin
              dd = 5'd1;
              if (m >= 12) begin
                mo = 4'd1;
                yy = (yy >= 14'd9999) ? 14'd0 : yy + 14'd1;
              end else begin
                mo = 4'(m + 1);
              end
            end else begin
              dd = dd + 5'd1;
            end
          end
        end else begin
          tick_cnt = 8'(cnt);
        end
      end
      MODE_LOAD_TIME: begin
        if (rq.set_hour <= 7'd23 && rq.set_minute <= 7'd59 && rq.set_second <= 7'd59) begin
          hh = 5'(rq.set_hour);
          mm = 6'(rq.set_minute);
          ss = 6'(rq.set_second);
        end else begin
          rej = 1'b1;
        end
      end
      MODE_LOAD_DATE: begin
        if (rq.set_month >= 7'd1 && rq.set_month <= 7'd12 && rq.set_year <= 14'd9999 &&
            rq.set_day >= 7'd1 && int'(rq.set_day) <= month_days(rq.set_month, rq.set_year))
        begin
          dd = 5'(rq.set_day);
          mo = 4'(rq.set_month);
          yy = rq.set_year;
        end else begin
          rej = 1'b1;
        end
      end
      default: ;
    endcase
    r = clock_reading(hh, mm, ss, dd, mo, yy, pulse, nday,
                      (hh == alm_h) && (mm == alm_m) && (ss == alm_s), rej);
    return r;
  endfunction

  // Build a random request: mostly ticks and loads aimed at rollovers and the alarm
  function automatic request_t random_request();
    request_t rq;
    int pick;
    int mon;
    int yr;
    rq = make_request(MODE_TICK, $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 127), $urandom_range(0, 16383));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      rq.mode = MODE_TICK;
    end else if (pick < 72) begin
      rq.mode = MODE_LOAD_TIME;
      case ($urandom_range(0, 2))
        0: begin
          rq.set_hour   = 7'd23;
          rq.set_minute = 7'd59;
          rq.set_second = 7'($urandom_range(50, 59));
        end
        1: begin
          // land on or just short of the alarm time
          rq.set_hour   = 7'(alm_h);
          rq.set_minute = 7'(alm_m);
          rq.set_second = 7'(alm_s) - 7'($urandom_range(0, (alm_s < 6'd3) ? alm_s : 3));
        end
        default: begin
          rq.set_hour   = 7'($urandom_range(0, 23));
          rq.set_minute = 7'($urandom_range(0, 59));
          rq.set_second = 7'($urandom_range(0, 59));
        end
      endcase
    end else if (pick < 84) begin
      rq.mode = MODE_LOAD_DATE;
      mon = $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0:       yr = 0;
        1:       yr = 1900;
        2:       yr = 2000;
        3:       yr = 2024;
        4:       yr = 2100;
        5, 6:    yr = 9999;
        default: yr = $urandom_range(0, 9999);
      endcase
      rq.set_month = 7'(mon);
      rq.set_year  = 14'(yr);
      // mostly the last day or two of the month
      if ($urandom_range(0, 3) == 0) begin
        rq.set_day = 7'($urandom_range(1, month_days(mon, yr)));
      end else begin
        rq.set_day = 7'(month_days(mon, yr) - $urandom_range(0, 1));
      end
    end else if (pick < 96) begin
      // raw field noise, mostly rejected
      rq.mode = ($urandom_range(0, 1) == 1) ? MODE_LOAD_TIME : MODE_LOAD_DATE;
    end else begin
      rq.mode = MODE_UNUSED;
    end
    return rq;
  endfunction

  task automatic add_row(request_t rq, bit typed, reading_t want);
    table_row_t row;
    row.rq    = rq;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Offer one request, hold it until taken, then queue the reading it must produce
  task automatic send_request(request_t rq, bit typed, reading_t want);
    reading_t predicted;
    while (!steady && $urandom_range(0, 99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, rq.set_year, rq.set_month, rq.set_day,
                      rq.set_second, rq.set_minute, rq.set_hour};
    s_axis_tuser  <= rq.mode;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_calendar(rq);
    pending_readings.push_back(typed ? want : predicted);
  endtask

  // Stop sending and wait until every queued reading has come back
  task automatic drain_readings();
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_TICKS_PER_SEC: tps_q = value;
      REG_ALARM_HOURS:   alm_h = value[4:0];
      REG_ALARM_MINUTES: alm_m = value[5:0];
      REG_ALARM_SECONDS: alm_s = value[5:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(int tps, int ah, int am, int as_val);
    write_reg(REG_TICKS_PER_SEC, 8'(tps));
    write_reg(REG_ALARM_HOURS, 8'(ah));
    write_reg(REG_ALARM_MINUTES, 8'(am));
    write_reg(REG_ALARM_SECONDS, 8'(as_val));
    cfg_we_i <= 1'b0;
  endtask

  task automatic report_mismatch(string want_text, reading_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch: expected %s, got %s", want_text, show_reading(got));
    end
  endtask

  // Stall the result side at random and check each result taken
  always @(posedge clk_i) begin : result_check
    reading_t got;
    reading_t want;
    m_axis_tready <= steady || ($urandom_range(0, 99) >= IdlePercent);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = reading_t'(m_axis_tdata[43:0]);
      if (pending_readings.size() == 0) begin
        report_mismatch("no result", got);
      end else begin
        want = pending_readings.pop_front();
        if (got !== want) begin
          report_mismatch(show_reading(want), got);
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int sent;
    request_t rq;

    // tick with every field at its top: only the prescaler moves
    add_row(make_request(MODE_TICK, 127, 127, 127, 127, 127, 16383), 1,
            clock_reading(18, 0, 0, 1, 1, 1991, 0, 0, 0, 0));
    // time loads out of range
    add_row(make_request(MODE_LOAD_TIME, 24, 0, 0, 0, 0, 0), 1,
            clock_reading(18, 0, 0, 1, 1, 1991, 0, 0, 0, 1));
    add_row(make_request(MODE_LOAD_TIME, 23, 60, 0, 0, 0, 0), 1,
            clock_reading(18, 0, 0, 1, 1, 1991, 0, 0, 0, 1));
    add_row(make_request(MODE_LOAD_TIME, 23, 0, 60, 0, 0, 0), 1,
            clock_reading(18, 0, 0, 1, 1, 1991, 0, 0, 0, 1));
    add_row(make_request(MODE_LOAD_TIME, 127, 127, 127, 0, 0, 0), 1,
            clock_reading(18, 0, 0, 1, 1, 1991, 0, 0, 0, 1));
    // last second of the last day of the last year
    add_row(make_request(MODE_LOAD_TIME, 23, 59, 59, 0, 0, 0), 1,
            clock_reading(23, 59, 59, 1, 1, 1991, 0, 0, 0, 0));
    add_row(make_request(MODE_LOAD_DATE, 0, 0, 0, 31, 12, 9999), 1,
            clock_reading(23, 59, 59, 31, 12, 9999, 0, 0, 0, 0));
    // date loads out of range
    add_row(make_request(MODE_LOAD_DATE, 0, 0, 0, 1, 1, 10000), 1,
            clock_reading(23, 59, 59, 31, 12, 9999, 0, 0, 0, 1));
    add_row(make_request(MODE_LOAD_DATE, 0, 0, 0, 1, 0, 2000), 1,
            clock_reading(23, 59, 59, 31, 12, 9999, 0, 0, 0, 1));
    add_row(make_request(MODE_LOAD_DATE, 0, 0, 0, 1, 13, 2000), 1,
            clock_reading(23, 59, 59, 31, 12, 9999, 0, 0, 0, 1));
    add_row(make_request(MODE_LOAD_DATE, 0, 0, 0, 0, 1, 2000), 1,
            clock_reading(23, 59, 59, 31, 12, 9999, 0, 0, 0, 1));
    add_row(make_request(MODE_LOAD_DATE, 0, 0, 0, 32, 1, 2000), 1,
            clock_reading(23, 59, 59, 31, 12, 9999, 0, 0, 0, 1));
    add_row(make_request(MODE_LOAD_DATE, 127, 127, 127, 127, 127, 16383), 1,
            clock_reading(23, 59, 59, 31, 12, 9999, 0, 0, 0, 1));
    // unused mode leaves everything alone
    add_row(make_request(MODE_UNUSED, 127, 127, 127, 127, 127, 16383), 1,
            clock_reading(23, 59, 59, 31, 12, 9999, 0, 0, 0, 0));
    // fill the prescaler, then wrap into year 0 right on the alarm
    repeat (4) begin
      add_row(make_request(MODE_TICK, 0, 0, 0, 0, 0, 0), 1,
              clock_reading(23, 59, 59, 31, 12, 9999, 0, 0, 0, 0));
    end
    add_row(make_request(MODE_TICK, 0, 0, 0, 0, 0, 0), 1,
            clock_reading(0, 0, 0, 1, 1, 0, 1, 1, 1, 0));
    // year 0 is a leap year, 1900 is not
    add_row(make_request(MODE_LOAD_DATE, 0, 0, 0, 29, 2, 0), 1,
            clock_reading(0, 0, 0, 29, 2, 0, 0, 0, 1, 0));
    add_row(make_request(MODE_LOAD_DATE, 0, 0, 0, 29, 2, 1900), 1,
            clock_reading(0, 0, 0, 29, 2, 0, 0, 0, 1, 1));
    add_row(make_request(MODE_LOAD_DATE, 0, 0, 0, 29, 2, 2000), 0, '0);
    add_row(make_request(MODE_LOAD_DATE, 0, 0, 0, 31, 4, 2023), 0, '0);
    add_row(make_request(MODE_LOAD_TIME, 0, 0, 1, 0, 0, 0), 0, '0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases, each under its own register setting
    for (int phase = 0; phase < 8; phase++) begin
      drain_readings();
      case (phase)
        0: program_regs(1, 23, 59, 59);
        1: program_regs(0, 0, 0, 0);
        2: program_regs(255, $urandom_range(0, 23), $urandom_range(0, 59),
                        $urandom_range(0, 59));
        3: program_regs(3, 31, 63, 63);
        5: program_regs($urandom_range(2, 12), $urandom_range(0, 23),
                        $urandom_range(0, 59), $urandom_range(0, 59));
        6: program_regs(2, $urandom_range(0, 23), $urandom_range(0, 59),
                        $urandom_range(0, 59));
        default: program_regs(1, $urandom_range(0, 23), $urandom_range(0, 59),
                              $urandom_range(0, 59));
      endcase
      steady = (phase == 4);
      sent = 0;
      while (sent < PhaseRequests) begin
        rq = random_request();
        if (rq.mode != MODE_UNUSED) begin
          sent++;
        end
        send_request(rq, 1'b0, '0);
      end
    end
    steady = 1'b0;
    drain_readings();

    mismatch_count += pending_readings.size();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
